/* hw/rtl/htmm_pkg.sv */
package htmm_pkg;

  localparam int MaxTracks = 1024;
  localparam int PosW = $clog2(MaxTracks);
  localparam int CordicIters = 24;
  localparam int IterW = 5;
  localparam logic [20:0] Kc = 21'd1287599;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic signed [33:0] Sat32Max = 34'sd2147483647;
  localparam logic signed [33:0] Sat32Min = -34'sd2147483648;
  localparam logic [1:0] RegFieldStrength = 2'd0;
  localparam logic [1:0] RegMatchTolerance = 2'd1;

  typedef struct packed {
    logic signed [23:0] tan_lambda;
    logic signed [31:0] curvature;
    logic signed [15:0] azimuth;
    logic signed [31:0] particle_px;
    logic signed [31:0] particle_py;
    logic signed [31:0] particle_pz;
    logic first_track;
    logic last_track;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] track_px;
    logic signed [31:0] track_py;
    logic signed [31:0] track_pz;
    logic within_tolerance;
    logic match_found;
    logic [9:0] match_index;
    logic search_done;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  function automatic logic signed [33:0] atan_val(input logic [IterW-1:0] i);
    logic signed [33:0] r;
    begin
      unique case (i)
        5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* hw/rtl/htmm_divider.sv */
module htmm_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic busy,
  output logic [63:0] quo
);

  logic [6:0] cnt;
  logic [32:0] rem;
  logic [63:0] q;
  logic [31:0] d;
  logic [33:0] trial;

  assign trial = {rem, q[63]} - {2'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      q <= num;
      d <= den;
    end else if (busy) begin
      if (trial[33]) begin
        rem <= {rem[31:0], q[63]};
        q <= {q[62:0], 1'b0};
      end else begin
        rem <= trial[32:0];
        q <= {q[62:0], 1'b1};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

endmodule

/* hw/rtl/htmm_cordic.sv */
module htmm_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [15:0] angle,
  output logic busy,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  logic [htmm_pkg::IterW-1:0] it;
  logic signed [33:0] x, y, z;
  logic neg;
  logic signed [16:0] a;
  logic signed [33:0] at;

  always_comb begin
    a = 17'(angle);
    if (angle > 16'sd16384) a = 17'(angle) - 17'sd32768;
    else if (angle < -16'sd16384) a = 17'(angle) + 17'sd32768;
  end

  assign at = htmm_pkg::atan_val(it);
  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      it <= '0;
    end else if (start) begin
      busy <= 1'b1;
      it <= '0;
      x <= htmm_pkg::CordicX0;
      y <= '0;
      z <= {a[16], a, 16'b0};
      neg <= (angle > 16'sd16384) || (angle < -16'sd16384);
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - (y >>> it);
        y <= y + (x >>> it);
        z <= z - at;
      end else begin
        x <= x + (y >>> it);
        y <= y - (x >>> it);
        z <= z + at;
      end
      it <= it + 1'b1;
      if (it == 5'(htmm_pkg::CordicIters - 1)) busy <= 1'b0;
    end
  end

endmodule

/* hw/rtl/helix_track_momentum_matcher_core.sv */
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_data  (htmm_pkg::in_beat_t)
// out     | out_valid | out_stall | out_data (htmm_pkg::out_beat_t)
// after a beat is accepted, the radix-2 64-step pT divider and the 24-step cordic
// run side by side, then three serial multiplies and a compare; the result stays
// valid while out_stall is high
// in_stall is high from acceptance until the result is taken
// rst is synchronous and restores register defaults and clears the search
module helix_track_momentum_matcher_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  htmm_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output htmm_pkg::out_beat_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [19:0] cfg_data
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun = 3'd1;
  localparam logic [2:0] StMul = 3'd2;
  localparam logic [2:0] StCmp = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0] state;
  logic [19:0] field_strength;
  logic [15:0] match_tolerance;
  logic found_flag;
  logic [htmm_pkg::PosW-1:0] first_pos, track_pos;
  htmm_pkg::in_beat_t item;
  logic [31:0] w;
  logic [63:0] quo;
  logic div_busy, cor_busy, go, sat;
  logic signed [33:0] c, s;
  logic [31:0] pt;
  logic [1:0] mstep;
  logic signed [33:0] tx, ty, tz;
  logic signed [33:0] mop;
  logic [4:0] mshift;
  logic signed [67:0] prod, rnd;
  logic signed [33:0] res;
  logic rsat, in_tol;
  logic [40:0] nump;
  htmm_pkg::unit_ctl_t ctl;

  assign go = in_valid && !in_stall;
  assign in_stall = state != StIdle;
  assign nump = 41'(field_strength) * 41'(htmm_pkg::Kc);
  assign w = in_data.curvature[31] ? 32'(-in_data.curvature) : in_data.curvature;
  assign ctl = '{start: go, done: !div_busy && !cor_busy};

  htmm_divider u_div (.clk(clk), .rst(rst), .start(ctl.start),
    .num(64'({nump, 8'b0}) + 64'(w >> 1)), .den(w), .busy(div_busy), .quo(quo));
  htmm_cordic u_cor (.clk(clk), .rst(rst), .start(ctl.start), .angle(in_data.azimuth),
    .busy(cor_busy), .cos_out(c), .sin_out(s));

  always_comb begin
    unique case (mstep)
      2'd0: begin mop = c; mshift = 5'd30; end
      2'd1: begin mop = s; mshift = 5'd30; end
      default: begin mop = 34'(item.tan_lambda); mshift = 5'd16; end
    endcase
  end
  assign prod = 68'($signed({1'b0, pt})) * 68'(mop);
  assign rnd = (prod + (68'sd1 <<< (mshift - 5'd1))) >>> mshift;
  assign rsat = (rnd > 68'(htmm_pkg::Sat32Max)) || (rnd < 68'(htmm_pkg::Sat32Min));
  assign res = rnd > 68'(htmm_pkg::Sat32Max) ? htmm_pkg::Sat32Max :
               rnd < 68'(htmm_pkg::Sat32Min) ? htmm_pkg::Sat32Min : 34'(rnd);

  function automatic logic near(input logic signed [33:0] a, input logic signed [31:0] b,
                                input logic [15:0] t);
    logic signed [34:0] d;
    begin
      d = 35'(a) - 35'(b);
      if (d < 0) d = -d;
      return d < 35'(t);
    end
  endfunction

  assign in_tol = !sat && near(tx, item.particle_px, match_tolerance)
    && near(ty, item.particle_py, match_tolerance)
    && near(tz, item.particle_pz, match_tolerance);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      field_strength <= 20'd229376;
      match_tolerance <= 16'd983;
      found_flag <= 1'b0;
      first_pos <= '0;
      track_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          htmm_pkg::RegFieldStrength: field_strength <= cfg_data;
          htmm_pkg::RegMatchTolerance: match_tolerance <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        StIdle: if (go) begin
          item <= in_data;
          sat <= w == 32'd0;
          if (in_data.first_track) begin
            found_flag <= 1'b0;
            first_pos <= '0;
            track_pos <= '0;
          end
          state <= StRun;
        end
        StRun: if (ctl.done) begin
          if (sat || quo > 64'd2147483647) begin
            pt <= 32'd2147483647;
            sat <= 1'b1;
          end else pt <= quo[31:0];
          mstep <= 2'd0;
          state <= StMul;
        end
        StMul: begin
          if (rsat) sat <= 1'b1;
          unique case (mstep)
            2'd0: tx <= res;
            2'd1: ty <= res;
            default: tz <= res;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd2) state <= StCmp;
        end
        StCmp: begin
          out_data.track_px <= tx[31:0];
          out_data.track_py <= ty[31:0];
          out_data.track_pz <= tz[31:0];
          out_data.within_tolerance <= in_tol;
          out_data.search_done <= item.last_track;
          if (in_tol && !found_flag) begin
            found_flag <= 1'b1;
            first_pos <= track_pos;
            out_data.match_index <= 10'(track_pos);
            out_data.match_found <= 1'b1;
          end else begin
            out_data.match_found <= found_flag;
            out_data.match_index <= found_flag ? 10'(first_pos) : 10'd0;
          end
          if (track_pos != htmm_pkg::PosW'(htmm_pkg::MaxTracks - 1))
            track_pos <= track_pos + 1'b1;
          out_valid <= 1'b1;
          state <= StOut;
        end
        StOut: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

/* hw/rtl/htmm_checker.sv */
module htmm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input htmm_pkg::out_beat_t out_data
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.match_found) |-> out_data.match_index == 10'd0)
    else $error("index without match");

endmodule

bind helix_track_momentum_matcher_core htmm_checker u_htmm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

/* verif/tb_helix_track_momentum_matcher_core.sv */
class momentum_scoreboard;
  logic [19:0] field;
  logic [15:0] tol;
  bit found;
  logic [9:0] first_pos;
  logic [9:0] pos;
  htmm_pkg::out_beat_t expected_q[$];
  int errors;
  int matched;
  int saturated;
  int done_searches;
  longint atan_steps[24];

  function new();
    atan_steps = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
    field = 20'd229376;
    tol = 16'd983;
    found = 0;
    first_pos = '0;
    pos = '0;
    errors = 0;
    matched = 0;
    saturated = 0;
    done_searches = 0;
  endfunction

  function longint clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function void momentum(htmm_pkg::in_beat_t b, output longint tx, output longint ty,
                         output longint tz, output bit sat);
    longint om, w, pt, num, tl, a, x, y, z, dx, dy;
    bit neg;
    sat = 0;
    neg = 0;
    om = b.curvature;
    tl = b.tan_lambda;
    a = b.azimuth;
    w = (om < 0) ? -om : om;
    if (w == 0) begin
      pt = 64'sd2147483647;
      sat = 1;
    end else begin
      num = (longint'(field) * 64'sd1287599) << 8;
      pt = (num + w / 2) / w;
      if (pt > 64'sd2147483647) begin
        pt = 64'sd2147483647;
        sat = 1;
      end
    end
    if (a > 16384) begin
      a -= 32768;
      neg = 1;
    end else if (a < -16384) begin
      a += 32768;
      neg = 1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_steps[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_steps[i];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    tx = clamp32((pt * x + (64'sd1 << 29)) >>> 30, sat);
    ty = clamp32((pt * y + (64'sd1 << 29)) >>> 30, sat);
    tz = clamp32((pt * tl + (64'sd1 << 15)) >>> 16, sat);
  endfunction

  function bit near(longint p, longint t);
    longint d;
    d = p - t;
    if (d < 0) d = -d;
    return d < longint'(tol);
  endfunction

  function void note_input(htmm_pkg::in_beat_t b);
    longint tx, ty, tz;
    bit sat, in_tol;
    htmm_pkg::out_beat_t r;
    if (b.first_track) begin
      found = 0;
      first_pos = '0;
      pos = '0;
    end
    momentum(b, tx, ty, tz, sat);
    in_tol = !sat && near(b.particle_px, tx) && near(b.particle_py, ty)
             && near(b.particle_pz, tz);
    if (in_tol && !found) begin
      found = 1;
      first_pos = pos;
    end
    if (in_tol) matched++;
    if (sat) saturated++;
    if (b.last_track) done_searches++;
    r.track_px = tx[31:0];
    r.track_py = ty[31:0];
    r.track_pz = tz[31:0];
    r.within_tolerance = in_tol;
    r.match_found = found;
    r.match_index = found ? first_pos : '0;
    r.search_done = b.last_track;
    expected_q = {expected_q, r};
    if (pos != 10'd1023) pos++;
  endfunction

  function void check_result(htmm_pkg::out_beat_t r);
    htmm_pkg::out_beat_t e;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (r.track_px !== e.track_px) begin
      $error("track_px expected %0d actual %0d", e.track_px, r.track_px);
      errors++;
    end
    if (r.track_py !== e.track_py) begin
      $error("track_py expected %0d actual %0d", e.track_py, r.track_py);
      errors++;
    end
    if (r.track_pz !== e.track_pz) begin
      $error("track_pz expected %0d actual %0d", e.track_pz, r.track_pz);
      errors++;
    end
    if (r.within_tolerance !== e.within_tolerance) begin
      $error("within_tolerance expected %0d actual %0d", e.within_tolerance,
             r.within_tolerance);
      errors++;
    end
    if (r.match_found !== e.match_found) begin
      $error("match_found expected %0d actual %0d", e.match_found, r.match_found);
      errors++;
    end
    if (r.match_index !== e.match_index) begin
      $error("match_index expected %0d actual %0d", e.match_index, r.match_index);
      errors++;
    end
    if (r.search_done !== e.search_done) begin
      $error("search_done expected %0d actual %0d", e.search_done, r.search_done);
      errors++;
    end
  endfunction
endclass

module tb_helix_track_momentum_matcher_core;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  htmm_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  htmm_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;

  momentum_scoreboard sb;
  bit idling;
  int beats_in;

  helix_track_momentum_matcher_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_helix_track_momentum_matcher_core failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
        beats_in++;
      end
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(negedge clk) begin
    out_stall <= idling ? ($urandom_range(99) < 29) : 1'b0;
  end

  task automatic send(htmm_pkg::in_beat_t b);
    if (idling) begin
      while ($urandom_range(99) < 29) begin
        in_valid = 0;
        @(negedge clk);
      end
    end
    in_valid = 1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == htmm_pkg::RegFieldStrength) sb.field = val;
    else sb.tol = val[15:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic longint near_value(longint t);
    longint off, v;
    off = (sb.tol == 0) ? 0 : $urandom_range(2 * (sb.tol - 1)) - longint'(sb.tol - 1);
    v = t + off;
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = t;
    return v;
  endfunction

  function automatic htmm_pkg::in_beat_t make_track(bit first, bit last, bit hit);
    htmm_pkg::in_beat_t b;
    longint tx, ty, tz;
    bit sat;
    b.tan_lambda = ($urandom_range(3) == 0) ? 24'($urandom)
                   : 24'($signed($urandom_range(131072)) - 65536);
    case ($urandom_range(7))
      0: b.curvature = '0;
      1: b.curvature = $urandom_range(255);
      default: b.curvature = $urandom;
    endcase
    b.azimuth = 16'($urandom);
    b.particle_px = $urandom;
    b.particle_py = $urandom;
    b.particle_pz = $urandom;
    b.first_track = first;
    b.last_track = last;
    if (hit) begin
      sb.momentum(b, tx, ty, tz, sat);
      b.particle_px = 32'(near_value(tx));
      b.particle_py = 32'(near_value(ty));
      b.particle_pz = 32'(near_value(tz));
    end
    return b;
  endfunction

  task automatic directed();
    htmm_pkg::in_beat_t b;
    logic signed [15:0] az_list[9];
    az_list = '{16'sh8000, 16'sh7fff, 16'sd16384, -16'sd16384, 16'sd16385,
                -16'sd16385, 16'sd0, 16'sd8192, -16'sd1};
    foreach (az_list[k]) begin
      b = make_track(k == 0, k == 8, k % 3 == 1);
      b.azimuth = az_list[k];
      if (k == 2) b.curvature = 32'sh80000000;
      if (k == 3) b.curvature = 32'sh7fffffff;
      if (k == 4) b.curvature = '0;
      if (k == 5) b.curvature = 32'sd1;
      if (k == 6) b.tan_lambda = 24'sh7fffff;
      if (k == 7) b.tan_lambda = 24'sh800000;
      send(b);
    end
    b = make_track(1, 0, 0);
    b.particle_px = 32'sh80000000;
    b.particle_py = 32'sh7fffffff;
    b.particle_pz = 32'sh80000000;
    send(b);
    send(make_track(0, 1, 1));
    send(make_track(0, 0, 1));
    send(make_track(0, 1, 0));
  endtask

  task automatic searches(int n);
    int len;
    bit broken;
    for (int s = 0; s < n; s++) begin
      len = $urandom_range(1, 12);
      broken = ($urandom_range(99) < 20);
      for (int t = 0; t < len; t++) begin
        send(make_track((t == 0) && !(broken && $urandom_range(1)),
                        (t == len - 1) || (broken && $urandom_range(5) == 0),
                        $urandom_range(99) < 30));
      end
    end
  endtask

  initial begin
    sb = new();
    idling = 1;
    beats_in = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = htmm_pkg::RegFieldStrength;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst = 0;

    directed();
    write_reg(htmm_pkg::RegFieldStrength, 20'hfffff);
    write_reg(htmm_pkg::RegMatchTolerance, 20'h0ffff);
    directed();
    write_reg(htmm_pkg::RegFieldStrength, 20'h00000);
    write_reg(htmm_pkg::RegMatchTolerance, 20'h00000);
    directed();
    write_reg(htmm_pkg::RegMatchTolerance, 20'd1);
    searches(4);
    write_reg(htmm_pkg::RegFieldStrength, 20'd229376);
    write_reg(htmm_pkg::RegMatchTolerance, 20'd983);
    searches(20);

    for (int p = 0; p < 6; p++) begin
      write_reg(htmm_pkg::RegFieldStrength, 20'($urandom_range(20'hfffff)));
      write_reg(htmm_pkg::RegMatchTolerance, 20'($urandom_range(16'hffff)));
      idling = (p != 2);
      searches(7);
    end
    idling = 1;

    drain();
    $display("%0d track beats, %0d matches, %0d saturated, %0d finished searches",
             beats_in, sb.matched, sb.saturated, sb.done_searches);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_helix_track_momentum_matcher_core passed");
    end else begin
      $display("tb_helix_track_momentum_matcher_core failed");
    end
    $finish;
  end
endmodule
